[design/gpe_pkg.sv]
// Package for the bitmap glyph pixel expander.
// Word types, register map, state enums and small helpers shared by the design files except gpe_ram.
// No dependencies.
package gpe_pkg;

    // Index arithmetic width: holds (code - first) * height, store address and store size
    localparam int ACC_W = 14;

    localparam logic [7:0] FOLD_FROM = 8'hC0;
    localparam logic [7:0] FOLD_BY   = 8'h60;
    localparam logic [7:0] DOT_CODE  = 8'h2E;

    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FIRST_CODE   = 3'd2;
    localparam logic [2:0] REG_LAST_CODE    = 3'd3;
    localparam logic [2:0] REG_FG_COLOR     = 3'd4;
    localparam logic [2:0] REG_BG_COLOR     = 3'd5;

    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [10:0] font_addr;
        logic [7:0]  font_byte;
        logic [7:0]  char_code;
        logic [7:0]  x_pos;
        logic [7:0]  y_pos;
    } gpe_in_t;

    typedef struct packed {
        logic        window_start;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [8:0]  x_end;
        logic [8:0]  y_end;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } gpe_out_t;

    typedef struct packed {
        logic [3:0]  glyph_width;
        logic [3:0]  glyph_height;
        logic [7:0]  first_code;
        logic [7:0]  last_code;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } gpe_cfg_t;

    typedef enum logic [1:0] {
        IX_IDLE,
        IX_MUL,
        IX_MOD
    } ix_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_FETCH,
        ST_PIXEL
    } top_state_t;

    // 0 is taken as 1, anything above 8 as 8
    function automatic logic [3:0] clamp_dim(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > 4'd8)
        begin
            r = 4'd8;
        end
        return r;
    endfunction

endpackage

[design/gpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/gpe_cfg.sv]
// APB configuration registers of the glyph expander.
// Depends on gpe_pkg.
module gpe_cfg
    import gpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output gpe_cfg_t    cfg
);

    gpe_cfg_t cfg_reg;
    gpe_cfg_t cfg_next;
    logic     wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_GLYPH_WIDTH:  cfg_next.glyph_width  = pwdata[3:0];
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = pwdata[3:0];
                REG_FIRST_CODE:   cfg_next.first_code   = pwdata[7:0];
                REG_LAST_CODE:    cfg_next.last_code    = pwdata[7:0];
                REG_FG_COLOR:     cfg_next.fg_color     = pwdata[15:0];
                REG_BG_COLOR:     cfg_next.bg_color     = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width  <= 4'd8;
            cfg_reg.glyph_height <= 4'd8;
            cfg_reg.first_code   <= 8'd32;
            cfg_reg.last_code    <= 8'd127;
            cfg_reg.fg_color     <= 16'hFFFF;
            cfg_reg.bg_color     <= 16'h0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_GLYPH_WIDTH:  prdata = {28'd0, cfg_reg.glyph_width};
            REG_GLYPH_HEIGHT: prdata = {28'd0, cfg_reg.glyph_height};
            REG_FIRST_CODE:   prdata = {24'd0, cfg_reg.first_code};
            REG_LAST_CODE:    prdata = {24'd0, cfg_reg.last_code};
            REG_FG_COLOR:     prdata = {16'd0, cfg_reg.fg_color};
            REG_BG_COLOR:     prdata = {16'd0, cfg_reg.bg_color};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[design/gpe_index.sv]
// Store address unit: bit-serial shift-add multiply, then modulo by repeated add/subtract.
// Depends on gpe_pkg.
module gpe_index
    import gpe_pkg::*;
#(
    parameter int FONT_ROWS = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic signed [ACC_W-1:0]      operand,
    input  logic [3:0]                   mult,
    output logic                         done,
    output logic [$clog2(FONT_ROWS)-1:0] idx
);

    localparam int AW = $clog2(FONT_ROWS);
    localparam logic signed [ACC_W-1:0] ROWS_S = ACC_W'(FONT_ROWS);

    ix_state_t state_reg, state_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [3:0] mult_reg, mult_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IX_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        done       = 1'b0;
        case (state_reg)
            IX_IDLE:
            begin
                if (go)
                begin
                    acc_next   = '0;
                    mcand_next = operand;
                    mult_next  = mult;
                    state_next = IX_MUL;
                end
            end
            IX_MUL:
            begin
                // one multiplier bit per cycle, LSB first
                if (mult_reg == 4'd0)
                begin
                    state_next = IX_MOD;
                end
                else
                begin
                    if (mult_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next = mcand_reg <<< 1;
                    mult_next  = mult_reg >> 1;
                end
            end
            IX_MOD:
            begin
                if (acc_reg < 0)
                begin
                    acc_next = acc_reg + ROWS_S;
                end
                else if (acc_reg >= ROWS_S)
                begin
                    acc_next = acc_reg - ROWS_S;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = IX_IDLE;
                end
            end
            default:
            begin
                state_next = IX_IDLE;
            end
        endcase
    end

    assign idx = acc_reg[AW-1:0];

endmodule

[design/bitmap_glyph_pixel_expander.sv]
// Top level of the bitmap glyph pixel expander: command handshake, sequencer, pixel shifter.
// Depends on gpe_pkg, gpe_cfg, gpe_index, gpe_ram.
//
// A word is taken when start is high and busy is low; busy stays high until the word is
// fully handled. A load word writes one font byte at the address that the index unit
// reduces modulo the store size. A draw word runs the bit-serial index unit (one shift-add
// step per bit of the height, up to 4, an end check and the add/subtract reduction), then
// for each glyph row a store read state and a fetch state followed by one pixel per cycle.
// Pixels appear on result with valid high for exactly one cycle each; the receiver cannot
// stall and must take every word as it comes.
module bitmap_glyph_pixel_expander
    import gpe_pkg::*;
#(
    parameter int FONT_ROWS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  gpe_in_t     cmd,
    output logic        valid,
    output gpe_out_t    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(FONT_ROWS);

    gpe_cfg_t cfg;

    top_state_t state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       first_reg, first_next;
    logic       load_reg, load_next;
    gpe_out_t   result_reg, result_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [8:0] x_end_reg, x_end_next;
    logic [8:0] y_end_reg, y_end_next;
    logic [3:0] w_reg, w_next;
    logic [3:0] h_reg, h_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] col_reg, col_next;
    logic [AW-1:0] addr_reg, addr_next;

    logic       accept;
    logic [3:0] w_cl;
    logic [3:0] h_cl;
    logic [7:0] folded;
    logic [7:0] code;
    logic signed [ACC_W-1:0] ix_operand;
    logic [3:0] ix_mult;
    logic       ix_done;
    logic [AW-1:0] ix_idx;
    logic       ram_we;
    logic       ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0] ram_rdata;
    logic       row_last;
    logic       col_last;

    gpe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign w_cl   = clamp_dim(cfg.glyph_width);
    assign h_cl   = clamp_dim(cfg.glyph_height);
    assign folded = (cmd.char_code >= FOLD_FROM) ? (cmd.char_code - FOLD_BY) : cmd.char_code;
    assign code   = (folded < cfg.first_code || folded > cfg.last_code) ? DOT_CODE : folded;

    always_comb
    begin
        if (cmd.action == ACT_LOAD)
        begin
            ix_operand = $signed(ACC_W'(cmd.font_addr));
            ix_mult    = 4'd1;
        end
        else
        begin
            ix_operand = $signed(ACC_W'(code)) - $signed(ACC_W'(cfg.first_code));
            ix_mult    = h_cl;
        end
    end

    gpe_index #(
        .FONT_ROWS (FONT_ROWS)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (accept),
        .operand (ix_operand),
        .mult    (ix_mult),
        .done    (ix_done),
        .idx     (ix_idx)
    );

    assign ram_waddr = ix_idx;

    gpe_ram #(
        .WIDTH (8),
        .DEPTH (FONT_ROWS)
    ) u_font (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign row_last = (row_reg == h_reg[2:0] - 3'd1);
    assign col_last = (col_reg == w_reg[2:0] - 3'd1);

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = 1'b0;
        first_next  = first_reg;
        load_next   = load_reg;
        result_next = result_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        x_end_next  = x_end_reg;
        y_end_next  = y_end_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        addr_next   = addr_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_next  = (cmd.action == ACT_LOAD);
                    byte_next  = cmd.font_byte;
                    x_next     = cmd.x_pos;
                    y_next     = cmd.y_pos;
                    x_end_next = {1'b0, cmd.x_pos} + {5'd0, w_cl} - 9'd1;
                    y_end_next = {1'b0, cmd.y_pos} + {5'd0, h_cl} - 9'd1;
                    w_next     = w_cl;
                    h_next     = h_cl;
                    row_next   = 3'd0;
                    col_next   = 3'd0;
                    first_next = 1'b1;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (ix_done)
                begin
                    if (load_reg)
                    begin
                        ram_we     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        addr_next  = ix_idx;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                shift_next = ram_rdata;
                col_next   = 3'd0;
                state_next = ST_PIXEL;
            end
            ST_PIXEL:
            begin
                valid_next               = 1'b1;
                result_next.window_start = first_reg;
                result_next.x_start      = first_reg ? x_reg : 8'd0;
                result_next.y_start      = first_reg ? y_reg : 8'd0;
                result_next.x_end        = first_reg ? x_end_reg : 9'd0;
                result_next.y_end        = first_reg ? y_end_reg : 9'd0;
                result_next.pixel_color  = shift_reg[7] ? cfg.fg_color : cfg.bg_color;
                result_next.last_pixel   = row_last && col_last;
                first_next               = 1'b0;
                shift_next               = {shift_reg[6:0], 1'b0};
                if (col_last)
                begin
                    col_next = 3'd0;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 3'd1;
                        addr_next  = (addr_reg == AW'(FONT_ROWS - 1)) ? '0 : addr_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    col_next = col_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
            load_reg  <= 1'b0;
            row_reg   <= 3'd0;
            col_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            first_reg <= first_next;
            load_reg  <= load_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        byte_reg   <= byte_next;
        shift_reg  <= shift_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        x_end_reg  <= x_end_next;
        y_end_reg  <= y_end_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        addr_reg   <= addr_next;
    end

    assign valid  = valid_reg;
    assign result = result_reg;

    // a taken word always makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // nothing follows the last pixel of a character directly
    assert property (@(posedge clk) disable iff (!rst_n) valid && result.last_pixel |=> !valid)
        else $error("pixel right after last pixel");

    // window fields only on the first pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.window_start |-> result.x_start == 8'd0 && result.y_start == 8'd0
            && result.x_end == 9'd0 && result.y_end == 9'd0)
        else $error("window fields set off the first pixel");

    // a load never produces a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INDEX && load_reg |=> !valid)
        else $error("pixel emitted for a load word");

endmodule

[dv/tb_bitmap_glyph_pixel_expander.sv]
// Self-checking testbench for bitmap_glyph_pixel_expander: font loads, glyph draws, APB setup.
// A scoreboard class predicts every pixel word from the loaded font and current registers.
// Depends on gpe_pkg and the bitmap_glyph_pixel_expander design files.
`timescale 1ns / 100ps

module tb_bitmap_glyph_pixel_expander
    import gpe_pkg::*;
;

    localparam int FONT_ROWS      = 2048;
    localparam int SETTLE_CYCLES  = 100;   // covers an 8x8 draw with margin
    localparam int WATCHDOG_LIMIT = 2000;

    // Scoreboard: font store mirror, register copy, queue of pixels still due
    class glyph_scoreboard;
        gpe_cfg_t    regs;
        logic [7:0]  rows [FONT_ROWS];
        bit          loaded [FONT_ROWS];
        gpe_out_t    pixels_due [$];
        int unsigned errors;
        int unsigned pixels_seen;

        function new();
            regs.glyph_width  = 4'd8;
            regs.glyph_height = 4'd8;
            regs.first_code   = 8'd32;
            regs.last_code    = 8'd127;
            regs.fg_color     = 16'hFFFF;
            regs.bg_color     = 16'h0000;
            for (int i = 0; i < FONT_ROWS; i++)
            begin
                rows[i]   = 8'h00;
                loaded[i] = 1'b0;
            end
            errors      = 0;
            pixels_seen = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] val);
            case (idx)
                REG_GLYPH_WIDTH:  regs.glyph_width  = val[3:0];
                REG_GLYPH_HEIGHT: regs.glyph_height = val[3:0];
                REG_FIRST_CODE:   regs.first_code   = val[7:0];
                REG_LAST_CODE:    regs.last_code    = val[7:0];
                REG_FG_COLOR:     regs.fg_color     = val[15:0];
                REG_BG_COLOR:     regs.bg_color     = val[15:0];
                default: ;
            endcase
        endfunction

        // 0 counts as 1, above 8 counts as 8
        function int dim(input logic [3:0] v);
            int d;
            d = int'(v);
            if (d == 0)
            begin
                d = 1;
            end
            else if (d > 8)
            begin
                d = 8;
            end
            return d;
        endfunction

        function logic [7:0] glyph_code(input logic [7:0] code);
            logic [7:0] k;
            k = code;
            if (k >= FOLD_FROM)
            begin
                k = k - FOLD_BY;
            end
            if (k < regs.first_code || k > regs.last_code)
            begin
                k = DOT_CODE;
            end
            return k;
        endfunction

        // negative index (glyph below first_code) wraps into the store
        function int unsigned row_addr(input logic [7:0] gcode, input int row);
            int a;
            a = (int'(gcode) - int'(regs.first_code)) * dim(regs.glyph_height) + row;
            a = a % FONT_ROWS;
            if (a < 0)
            begin
                a = a + FONT_ROWS;
            end
            return a;
        endfunction

        function void note_cmd(input gpe_in_t c);
            int          w;
            int          h;
            logic [7:0]  gcode;
            logic [7:0]  bits;
            gpe_out_t    px;
            int unsigned a;
            if (c.action == ACT_LOAD)
            begin
                a = int'(c.font_addr) % FONT_ROWS;
                rows[a]   = c.font_byte;
                loaded[a] = 1'b1;
                return;
            end
            w     = dim(regs.glyph_width);
            h     = dim(regs.glyph_height);
            gcode = glyph_code(c.char_code);
            for (int r = 0; r < h; r++)
            begin
                bits = rows[row_addr(gcode, r)];
                for (int col = 0; col < w; col++)
                begin
                    px = '0;
                    if (r == 0 && col == 0)
                    begin
                        px.window_start = 1'b1;
                        px.x_start      = c.x_pos;
                        px.y_start      = c.y_pos;
                        px.x_end        = 9'(int'(c.x_pos) + w - 1);
                        px.y_end        = 9'(int'(c.y_pos) + h - 1);
                    end
                    px.pixel_color = bits[7 - col] ? regs.fg_color : regs.bg_color;
                    px.last_pixel  = (r == h - 1 && col == w - 1);
                    pixels_due.push_back(px);
                end
            end
        endfunction

        function string fmt(input gpe_out_t p);
            return $sformatf("ws=%0d xs=%0d ys=%0d xe=%0d ye=%0d color=%h last=%0d",
                             p.window_start, p.x_start, p.y_start, p.x_end, p.y_end,
                             p.pixel_color, p.last_pixel);
        endfunction

        function void check_pixel(input gpe_out_t got);
            gpe_out_t want;
            if (pixels_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected pixel word: %s", fmt(got));
                end
                return;
            end
            want = pixels_due.pop_front();
            pixels_seen++;
            if (got.window_start !== want.window_start || got.x_start !== want.x_start ||
                got.y_start !== want.y_start || got.x_end !== want.x_end ||
                got.y_end !== want.y_end || got.pixel_color !== want.pixel_color ||
                got.last_pixel !== want.last_pixel)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("pixel %0d mismatch at %0t", pixels_seen, $realtime);
                    $display("  expected %s", fmt(want));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    gpe_in_t     cmd;
    logic        valid;
    gpe_out_t    result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glyph_scoreboard sb = new();

    bit          calm;
    int unsigned draws_sent;
    int unsigned loads_sent;
    int unsigned settings_used;
    int unsigned quiet_cycles;

    bitmap_glyph_pixel_expander #(
        .FONT_ROWS (FONT_ROWS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .valid   (valid),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            sb.check_pixel(result);
        end
    end

    // counts cycles with neither a command nor a pixel word accepted
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_cmd(input gpe_in_t c);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 20)
        begin
            gap = ($urandom_range(1) == 0) ? $urandom_range(8, 1) : $urandom_range(90, 9);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(c);
        if (c.action == ACT_LOAD)
        begin
            loads_sent++;
        end
        else
        begin
            draws_sent++;
        end
    endtask

    task automatic send_load(input logic [10:0] addr, input logic [7:0] data);
        gpe_in_t c;
        c           = gpe_in_t'({$urandom(), $urandom()});
        c.action    = ACT_LOAD;
        c.font_addr = addr;
        c.font_byte = data;
        send_cmd(c);
    endtask

    // loads any glyph row the draw would read that was never written
    task automatic send_draw(input logic [7:0] code, input logic [7:0] x, input logic [7:0] y);
        gpe_in_t     c;
        int unsigned a;
        for (int r = 0; r < sb.dim(sb.regs.glyph_height); r++)
        begin
            a = sb.row_addr(sb.glyph_code(code), r);
            if (!sb.loaded[a])
            begin
                send_load(11'(a), 8'($urandom()));
            end
        end
        c           = gpe_in_t'({$urandom(), $urandom()});
        c.action    = ACT_DRAW;
        c.char_code = code;
        c.x_pos     = x;
        c.y_pos     = y;
        send_cmd(c);
    endtask

    // block idle: no pixel due, load latency passed, busy low
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] word;
        word = $urandom();   // bits above the field are junk the block must drop
        case (idx)
            REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT: word[3:0] = val[3:0];
            REG_FIRST_CODE, REG_LAST_CODE:     word[7:0] = val[7:0];
            default:                           word[15:0] = val[15:0];
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(input logic [3:0] w, input logic [3:0] h,
                            input logic [7:0] first, input logic [7:0] last,
                            input logic [15:0] fg, input logic [15:0] bg);
        settle();
        write_reg(REG_GLYPH_WIDTH, 32'(w));
        write_reg(REG_GLYPH_HEIGHT, 32'(h));
        write_reg(REG_FIRST_CODE, 32'(first));
        write_reg(REG_LAST_CODE, 32'(last));
        write_reg(REG_FG_COLOR, 32'(fg));
        write_reg(REG_BG_COLOR, 32'(bg));
        settings_used++;
    endtask

    function automatic logic [7:0] edge_biased();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
        begin
            return 8'h00;
        end
        if (sel < 10)
        begin
            return 8'hFF;
        end
        return 8'($urandom());
    endfunction

    // mostly draws of in-range or folded codes, some stray loads and raw codes
    task automatic random_run(input int n);
        int         sel;
        logic [7:0] code;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
            begin
                send_load(11'($urandom()), 8'($urandom()));
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 55 && sb.regs.first_code <= sb.regs.last_code)
                begin
                    code = 8'($urandom_range(sb.regs.last_code, sb.regs.first_code));
                end
                else if (sel < 75)
                begin
                    code = 8'($urandom_range(255, 192));
                end
                else
                begin
                    code = 8'($urandom());
                end
                send_draw(code, edge_biased(), edge_biased());
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        draws_sent    = 0;
        loads_sent    = 0;
        settings_used = 1;
        quiet_cycles  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: one-row glyphs keep the preloading short
        write_reg(REG_GLYPH_HEIGHT, 32'd1);
        send_load(11'd0, 8'hFF);
        send_load(11'd2047, 8'h00);
        send_draw(8'h20, 8'd0, 8'd0);       // first code
        send_draw(8'h7F, 8'd255, 8'd255);   // last code, window end past 255
        send_draw(8'h1F, 8'd1, 8'd2);       // below range, dot
        send_draw(8'h80, 8'd3, 8'd4);       // above range, dot
        send_draw(8'hC0, 8'd5, 8'd6);       // folded into range
        send_draw(8'hDF, 8'd7, 8'd8);       // folded onto last code
        send_draw(8'hFF, 8'd9, 8'd10);      // folded but still out of range
        send_load(11'd0, 8'h00);            // overwrite a glyph row, then redraw
        send_draw(8'h20, 8'd128, 8'd64);
        send_load(11'd0, 8'hA5);
        send_draw(8'h20, 8'd255, 8'd0);

        // full-size glyphs pull in up to eight row loads per new glyph
        set_mode(4'd8, 4'd8, 8'd32, 8'd127, 16'hFFFF, 16'h0000);
        random_run(5);
        calm = 1'b1;
        set_mode(4'd1, 4'd1, 8'd0, 8'd255, 16'h0000, 16'hFFFF);
        random_run(18);
        calm = 1'b0;
        // empty range: every code draws the dot, at a wrapped index
        set_mode(4'd0, 4'd0, 8'd255, 8'd0, 16'($urandom()), 16'($urandom()));
        random_run(20);
        set_mode(4'd15, 4'd15, 8'h60, 8'h9F, 16'($urandom()), 16'($urandom()));
        random_run(4);
        set_mode(4'($urandom()), 4'($urandom()), 8'($urandom()), 8'($urandom()),
                 16'($urandom()), 16'($urandom()));
        random_run(6);
        set_mode(4'd8, 4'd8, 8'd0, 8'd255, 16'($urandom()), 16'($urandom()));
        random_run(3);

        settle();
        $display("ran %0d draw words and %0d load words over %0d register settings",
                 draws_sent, loads_sent, settings_used);
        $display("checked %0d pixel words, %0d mismatches", sb.pixels_seen, sb.errors);
        if (sb.errors == 0 && sb.pixels_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
